// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge out of reset.
`define ACQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// A condition that must never be true at a rising edge out of reset.
`define ACQ_NEVER(label, expr, msg) \
	`ACQ_ASSERT(label, !(expr), msg)

`endif

// File: rtl/core/acq_pkg.sv
// ----------------------------------------------------------------------------
// acq_pkg
// Types, constants and character classification shared by the address
// component quoter.
// ----------------------------------------------------------------------------
package acq_pkg;

	// Width of the size limit register and of all byte counts.
	localparam int LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] SIZE_LIMIT_RST = 7'd65;

	// Configuration register indexes.
	localparam int REG_W = 1;
	localparam logic [REG_W-1:0] REG_CHAR_SET_MODE = 1'b0;
	localparam logic [REG_W-1:0] REG_SIZE_LIMIT    = 1'b1;

	// Character set modes.
	localparam logic MODE_DISPLAY = 1'b0;
	localparam logic MODE_LOCAL   = 1'b1;

	// Characters with a role of their own.
	localparam logic [7:0] QUOTE     = 8'h22;
	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] TAB       = 8'h09;
	localparam logic [7:0] SPACE     = 8'h20;
	localparam logic [7:0] PERIOD    = 8'h2E;

	// One finished component handed from the loader to the replay engine.
	typedef struct packed {
		logic               bank;
		logic               special;
		logic [LIMIT_W-1:0] cnt;
		logic [LIMIT_W-1:0] cap;
	} desc_t;

	// Release of a store bank once its component has been replayed.
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	// One output request.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PRE,
		BK_BODY,
		BK_POST,
		BK_LONE
	} back_state_t;

	// True when the byte lies in the special set of the selected mode.
	function automatic logic is_special(input logic mode, input logic [7:0] b);
		logic common;
		// " ( ) , : ; < > @ [ \ ] are special in both modes.
		common = (b == QUOTE) || (b == 8'h28) || (b == 8'h29) || (b == 8'h2C) ||
			(b == 8'h3A) || (b == 8'h3B) || (b == 8'h3C) || (b == 8'h3E) ||
			(b == 8'h40) || (b == 8'h5B) || (b == BACKSLASH) || (b == 8'h5D);
		if (mode == MODE_LOCAL) begin
			return common || (b == TAB) || (b == SPACE);
		end
		return common || (b == PERIOD);
	endfunction

	// The four bytes that replace a component made of one lone quote.
	function automatic logic [7:0] lone_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd1:    b = BACKSLASH;
			default: b = QUOTE;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/core/address_component_quoter.sv
// ----------------------------------------------------------------------------
// address_component_quoter
// Quotes one mail address component for a display name or a local part.
// ----------------------------------------------------------------------------
// Input bytes load at one per cycle, while the bank being loaded is free,
// into one bank of a two-bank store, while the other bank replays the
// previous component, so loading and output overlap. Replay starts once a
// component is queued and then produces one output request per cycle for
// each plain byte while the output queue has room, with one more request
// for each opening quote, backslash or closing quote; a lone quote expands
// to quote, backslash, quote, quote. full rises only when both banks still
// hold components that have not been fully replayed.
module address_component_quoter #(
	parameter int NAME_SIZE = 65
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  in_byte,
	input  logic                        byte_present,
	input  logic                        in_last,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  out_byte,
	output logic                        out_last,
	input  logic                        cfg_we,
	input  logic [acq_pkg::REG_W-1:0]   cfg_index,
	input  logic [acq_pkg::LIMIT_W-1:0] cfg_data
);

	import acq_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (NAME_SIZE > 2) ? $clog2(NAME_SIZE - 1) : 1;

	logic               mode_q;
	logic [LIMIT_W-1:0] limit_q;

	logic               st_wr_en;
	logic [AW:0]        st_wr_addr;
	logic [7:0]         st_wr_data;
	logic               st_rd_en;
	logic [AW:0]        st_rd_addr;
	logic [7:0]         st_rd_data;

	logic               desc_push;
	desc_t              desc_data;
	logic               desc_full;
	logic               desc_pop;
	desc_t              desc_head;
	logic               desc_empty;

	rel_t               rel;
	logic               out_push;
	out_item_t          out_item;
	logic               out_full;
	out_item_t          out_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_DISPLAY;
			limit_q <= SIZE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHAR_SET_MODE: mode_q  <= cfg_data[0];
				REG_SIZE_LIMIT:    limit_q <= cfg_data;
				default:           limit_q <= limit_q;
			endcase
		end
	end

	// Loader.
	acq_front #(
		.NAME_SIZE (NAME_SIZE),
		.AW        (AW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.in_byte       (in_byte),
		.byte_present  (byte_present),
		.in_last       (in_last),
		.char_set_mode (mode_q),
		.size_limit    (limit_q),
		.rel           (rel),
		.wr_en         (st_wr_en),
		.wr_addr       (st_wr_addr),
		.wr_data       (st_wr_data),
		.desc_push     (desc_push),
		.desc_data     (desc_data)
	);

	// Two-bank byte store.
	acq_store #(
		.AW (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	// Queue of finished components between loader and replay.
	acq_fifo #(
		.W ($bits(desc_t))
	) u_desc_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (desc_push),
		.push_data (desc_data),
		.full      (desc_full),
		.pop       (desc_pop),
		.pop_data  (desc_head),
		.empty     (desc_empty)
	);

	// Replay engine.
	acq_back #(
		.AW (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_empty (desc_empty),
		.desc_head  (desc_head),
		.desc_pop   (desc_pop),
		.rd_en      (st_rd_en),
		.rd_addr    (st_rd_addr),
		.rd_data    (st_rd_data),
		.out_full   (out_full),
		.out_push   (out_push),
		.out_item   (out_item),
		.rel        (rel)
	);

	// Output queue.
	acq_fifo #(
		.W ($bits(out_item_t))
	) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (out_push),
		.push_data (out_item),
		.full      (out_full),
		.pop       (pop),
		.pop_data  (out_head),
		.empty     (empty)
	);

	assign out_byte = out_head.data;
	assign out_last = out_head.last;

	// Checks on the internal handoffs.
	`ACQ_NEVER(a_desc_no_overflow, desc_push && desc_full, "component queue overflow")
	`ACQ_NEVER(a_out_no_overflow, out_push && out_full, "output queue overflow")
	`ACQ_ASSERT(a_write_on_accept, st_wr_en |-> (push && !full), "store written without request")
	`ACQ_ASSERT(a_release_at_end, rel.valid |-> (out_push && out_item.last), "bank freed early")

endmodule

// File: rtl/core/acq_fifo.sv
// ----------------------------------------------------------------------------
// acq_fifo
// Two-entry queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module acq_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/acq_store.sv
// ----------------------------------------------------------------------------
// acq_store
// Two-bank byte store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module acq_store #(
	parameter int AW = 6
) (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [AW:0] wr_addr,
	input  logic [7:0]  wr_data,
	input  logic        rd_en,
	input  logic [AW:0] rd_addr,
	output logic [7:0]  rd_data
);

	localparam int DEPTH = 2 * (1 << AW);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	assign rd_data = rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/acq_front.sv
// ----------------------------------------------------------------------------
// acq_front
// Loads component bytes into the current store bank, tracks specials and
// hands each finished component to the replay side.
// ----------------------------------------------------------------------------
module acq_front #(
	parameter int NAME_SIZE = 65,
	parameter int AW        = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    in_byte,
	input  logic                          byte_present,
	input  logic                          in_last,
	input  logic                          char_set_mode,
	input  logic [acq_pkg::LIMIT_W-1:0]   size_limit,
	input  acq_pkg::rel_t                 rel,
	output logic                          wr_en,
	output logic [AW:0]                   wr_addr,
	output logic [7:0]                    wr_data,
	output logic                          desc_push,
	output acq_pkg::desc_t                desc_data
);

	import acq_pkg::*;

	logic [LIMIT_W-1:0] lim;
	logic [LIMIT_W-1:0] cap;
	logic [LIMIT_W-1:0] cnt_q;
	logic [LIMIT_W-1:0] cnt_new;
	logic               special_q;
	logic               special_new;
	logic               wbank_q;
	logic [1:0]         busy_q;
	logic               accept;
	logic               store_ok;

	// The bank being loaded is free only once its last replay has finished.
	assign full   = busy_q[wbank_q];
	assign accept = push && !full;

	// Clamp the size limit into the supported range.
	always_comb begin
		if (size_limit < LIMIT_W'(2)) begin
			lim = LIMIT_W'(2);
		end else if (size_limit > LIMIT_W'(NAME_SIZE)) begin
			lim = LIMIT_W'(NAME_SIZE);
		end else begin
			lim = size_limit;
		end
	end
	assign cap = lim - LIMIT_W'(1);

	// Store the byte while there is room and classify it.
	assign store_ok    = byte_present && (cnt_q < cap);
	assign cnt_new     = cnt_q + LIMIT_W'(store_ok);
	assign special_new = special_q || (store_ok && is_special(char_set_mode, in_byte));

	assign wr_en   = accept && store_ok;
	assign wr_addr = {wbank_q, cnt_q[AW-1:0]};
	assign wr_data = in_byte;

	// An empty component produces no request at all.
	assign desc_push         = accept && in_last && (cnt_new != '0);
	assign desc_data.bank    = wbank_q;
	assign desc_data.special = special_new;
	assign desc_data.cnt     = cnt_new;
	assign desc_data.cap     = cap;

	// Component progress and bank ownership.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			special_q <= 1'b0;
			wbank_q   <= 1'b0;
			busy_q    <= 2'b00;
		end else begin
			if (accept) begin
				if (in_last) begin
					cnt_q     <= '0;
					special_q <= 1'b0;
				end else begin
					cnt_q     <= cnt_new;
					special_q <= special_new;
				end
			end
			if (desc_push) begin
				wbank_q <= !wbank_q;
			end
			for (int b = 0; b < 2; b++) begin
				busy_q[b] <= (busy_q[b] && !(rel.valid && (rel.bank == 1'(b)))) ||
					(desc_push && (wbank_q == 1'(b)));
			end
		end
	end

endmodule

// File: rtl/core/acq_back.sv
// ----------------------------------------------------------------------------
// acq_back
// Replays one stored component, adding quotes and backslashes where the
// component needs quoting and truncating to the captured capacity.
// ----------------------------------------------------------------------------
module acq_back #(
	parameter int AW = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               desc_empty,
	input  acq_pkg::desc_t     desc_head,
	output logic               desc_pop,
	output logic               rd_en,
	output logic [AW:0]        rd_addr,
	input  logic [7:0]         rd_data,
	input  logic               out_full,
	output logic               out_push,
	output acq_pkg::out_item_t out_item,
	output acq_pkg::rel_t      rel
);

	import acq_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	desc_t              desc_q;
	logic [AW-1:0]      idx_q;
	logic [LIMIT_W-1:0] emitted_q;
	logic [7:0]         prev_q;
	logic [1:0]         lone_q;

	logic [7:0]         cur;
	logic               is_first;
	logic               is_lastb;
	logic               lone;
	logic               need_pre;
	logic               need_post;
	logic               emit;
	logic [7:0]         emit_byte;
	logic               seq_final;
	logic               body_fire;
	logic               done;

	// Classification of the byte now read from the store.
	assign cur       = rd_data;
	assign is_first  = (idx_q == '0);
	assign is_lastb  = ((LIMIT_W'(idx_q) + LIMIT_W'(1)) == desc_q.cnt);
	assign lone      = desc_q.special && (desc_q.cnt == LIMIT_W'(1)) && (cur == QUOTE);
	assign need_pre  = desc_q.special && (is_first ? (cur != QUOTE) :
		((cur == QUOTE) && !is_lastb && (prev_q != BACKSLASH)));
	assign need_post = desc_q.special && is_lastb && (cur != QUOTE);

	// Output selection per state.
	always_comb begin
		desc_pop  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = {desc_head.bank, {AW{1'b0}}};
		emit      = 1'b0;
		emit_byte = cur;
		seq_final = 1'b0;
		body_fire = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				desc_pop = !desc_empty;
				rd_en    = !desc_empty;
			end
			BK_PRE, BK_BODY: begin
				if (state_q == BK_PRE && lone) begin
					emit = 1'b0;
				end else if (state_q == BK_PRE && need_pre) begin
					emit      = 1'b1;
					emit_byte = is_first ? QUOTE : BACKSLASH;
				end else begin
					emit      = 1'b1;
					emit_byte = cur;
					seq_final = is_lastb && !need_post;
					body_fire = 1'b1;
				end
			end
			BK_POST: begin
				emit      = 1'b1;
				emit_byte = QUOTE;
				seq_final = 1'b1;
			end
			BK_LONE: begin
				emit      = 1'b1;
				emit_byte = lone_byte(lone_q);
				seq_final = (lone_q == 2'd3);
			end
			default: begin
				emit = 1'b0;
			end
		endcase

		out_push      = emit && !out_full;
		out_item.data = emit_byte;
		out_item.last = seq_final || ((emitted_q + LIMIT_W'(1)) == desc_q.cap);
		done          = out_push && out_item.last;
		body_fire     = body_fire && out_push;

		// Fetch the next stored byte as soon as this one is consumed.
		if (body_fire && !done && !is_lastb) begin
			rd_en   = 1'b1;
			rd_addr = {desc_q.bank, idx_q + AW'(1)};
		end

		rel.valid = done;
		rel.bank  = desc_q.bank;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!desc_empty) begin
					state_d = BK_PRE;
				end
			end
			BK_PRE: begin
				if (lone) begin
					state_d = BK_LONE;
				end else if (need_pre) begin
					if (out_push) begin
						state_d = BK_BODY;
					end
				end else if (out_push) begin
					state_d = is_lastb ? BK_POST : BK_PRE;
				end
			end
			BK_BODY: begin
				if (out_push) begin
					state_d = is_lastb ? BK_POST : BK_PRE;
				end
			end
			BK_POST, BK_LONE: begin
				state_d = state_q;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
		if (done) begin
			state_d = BK_IDLE;
		end
	end

	// State and progress registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			idx_q     <= '0;
			emitted_q <= '0;
			lone_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			if (desc_pop) begin
				idx_q     <= '0;
				emitted_q <= '0;
			end else if (out_push) begin
				emitted_q <= emitted_q + LIMIT_W'(1);
			end
			if (body_fire) begin
				idx_q <= idx_q + AW'(1);
			end
			if (state_q == BK_PRE && lone) begin
				lone_q <= 2'd0;
			end else if (state_q == BK_LONE && out_push) begin
				lone_q <= lone_q + 2'd1;
			end
		end
	end

	// Captured component and previous stored byte.
	always_ff @(posedge clk) begin
		if (desc_pop) begin
			desc_q <= desc_head;
		end
		if (body_fire) begin
			prev_q <= cur;
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the address component quoter. Components are
// pushed byte by byte through the request port and the quoted or unchanged
// output is predicted in step with every accepted request. Each popped byte
// is compared with the oldest predicted byte. The run uses directed corner
// cases first and then random components under changing register settings,
// with random gaps on both the input and the output side.
// ----------------------------------------------------------------------------

// Tracks the component being loaded and holds the output bytes still due.
class quote_tracker;
	localparam int NAME_SIZE = 65;

	logic                        mode;
	logic [acq_pkg::LIMIT_W-1:0] limit;
	logic [7:0]                  held[NAME_SIZE-1];
	int unsigned                 held_count;
	bit                          special_held;
	acq_pkg::out_item_t          due[$];
	int unsigned                 requests;
	int unsigned                 components;
	int unsigned                 settings;
	int unsigned                 checked;
	int unsigned                 errors;

	function new();
		mode         = acq_pkg::MODE_DISPLAY;
		limit        = acq_pkg::SIZE_LIMIT_RST;
		held_count   = 0;
		special_held = 0;
		requests     = 0;
		components   = 0;
		settings     = 0;
		checked      = 0;
		errors       = 0;
	endfunction

	function void write_reg(input logic [acq_pkg::REG_W-1:0] idx,
			input logic [acq_pkg::LIMIT_W-1:0] val);
		settings++;
		if (idx == acq_pkg::REG_CHAR_SET_MODE) begin
			mode = val[0];
		end else begin
			limit = val;
		end
	endfunction

	// Number of bytes that the store and one output may hold.
	function int unsigned room();
		int unsigned lim;
		lim = limit;
		if (lim < 2) lim = 2;
		if (lim > NAME_SIZE) lim = NAME_SIZE;
		return lim - 1;
	endfunction

	// True when the byte forces the component into quotes in the current mode.
	function bit needs_quotes(input logic [7:0] b);
		string set;
		set = (mode == acq_pkg::MODE_LOCAL) ? "\t \"(),:;<>@[\\]" : "\"(),.:;<>@[\\]";
		for (int i = 0; i < set.len(); i++) begin
			if (set[i] == b) return 1;
		end
		return 0;
	endfunction

	// Notes one accepted request and, on the last one, queues the output bytes.
	function void take_request(input logic [7:0] b, input logic present, input logic last);
		logic [7:0]         text[$];
		acq_pkg::out_item_t item;
		int unsigned        cap;
		int unsigned        n;
		logic [7:0]         c;
		cap = room();
		requests++;
		if (present && held_count < cap) begin
			held[held_count] = b;
			held_count++;
			if (needs_quotes(b)) special_held = 1;
		end
		if (!last) return;
		components++;
		n = held_count;
		if (!special_held) begin
			for (int i = 0; i < n; i++) text.push_back(held[i]);
		end else if (n == 1 && held[0] == acq_pkg::QUOTE) begin
			// A lone quote expands to quote, backslash, quote, quote.
			text.push_back(acq_pkg::QUOTE);
			text.push_back(acq_pkg::BACKSLASH);
			text.push_back(acq_pkg::QUOTE);
			text.push_back(acq_pkg::QUOTE);
		end else begin
			for (int i = 0; i < n; i++) begin
				c = held[i];
				if (i == 0) begin
					if (c != acq_pkg::QUOTE) text.push_back(acq_pkg::QUOTE);
				end else if (c == acq_pkg::QUOTE && i + 1 != n &&
						held[i-1] != acq_pkg::BACKSLASH) begin
					text.push_back(acq_pkg::BACKSLASH);
				end
				text.push_back(c);
				if (i + 1 == n && c != acq_pkg::QUOTE) text.push_back(acq_pkg::QUOTE);
			end
		end
		// The output is cut to the capacity in force at the last request.
		for (int i = 0; i < text.size() && i < cap; i++) begin
			item.data = text[i];
			item.last = (i + 1 == text.size()) || (i + 1 == cap);
			due.push_back(item);
		end
		held_count   = 0;
		special_held = 0;
	endfunction

	// Compares one popped byte with the oldest byte still due.
	function void match_output(input logic [7:0] b, input logic last);
		acq_pkg::out_item_t want;
		checked++;
		if (due.size() == 0) begin
			errors++;
			$display("%0t: unexpected output, expected none, actual byte %h last %b",
				$time, b, last);
			return;
		end
		want = due.pop_front();
		if (b !== want.data) begin
			errors++;
			$display("%0t: out_byte mismatch, expected %h, actual %h", $time, want.data, b);
		end
		if (last !== want.last) begin
			errors++;
			$display("%0t: out_last mismatch, expected %b, actual %b", $time, want.last, last);
		end
	endfunction
endclass

module tb_top;
	localparam int SETTLE_CYCLES = 300;
	localparam int ITEM_TARGET   = 255;
	localparam int PHASE_ITEMS   = 30;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] in_byte;
	logic byte_present;
	logic in_last;
	logic empty;
	logic pop;
	logic [7:0] out_byte;
	logic out_last;
	logic cfg_we;
	logic [acq_pkg::REG_W-1:0] cfg_index;
	logic [acq_pkg::LIMIT_W-1:0] cfg_data;
	bit steady;

	quote_tracker tracker;

	address_component_quoter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.byte_present (byte_present),
		.in_last      (in_last),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Random gap decision shared by both sides; no gaps during a steady stretch.
	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < 34);
	endfunction

	// The output side stalls at random.
	always @(negedge clk) begin
		pop <= !idle_now();
	end

	// Every popped byte is checked at the edge where it is taken.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			tracker.match_output(out_byte, out_last);
		end
	end

	// Writes one configuration register and mirrors it in the tracker.
	task automatic write_reg(input logic [acq_pkg::REG_W-1:0] idx,
			input logic [acq_pkg::LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tracker.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one request, with random gaps, and waits until it is taken.
	task automatic send_item(input logic [7:0] b, input logic present, input logic last);
		while (idle_now()) begin
			@(negedge clk);
			push <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		push         <= 1'b1;
		in_byte      <= b;
		byte_present <= present;
		in_last      <= last;
		@(posedge clk);
		while (full) @(posedge clk);
		tracker.take_request(b, present, last);
	endtask

	// Stops pushing and waits until every due byte has come out and the block is quiet.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		@(posedge clk);
		while (tracker.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Picks one byte, either from plain text or weighted toward quoting triggers.
	function automatic logic [7:0] pick_byte(input bit plain);
		string pool;
		int unsigned r;
		pool = "\t .(),:;<>@[]";
		r = $urandom_range(99);
		if (plain) begin
			if (r < 45) return 8'($urandom_range(8'h61, 8'h7A));
			if (r < 70) return 8'($urandom_range(8'h80, 8'hFF));
			if (r < 95) return 8'($urandom_range(8'h30, 8'h39));
			return 8'h00;
		end
		if (r < 14) return acq_pkg::QUOTE;
		if (r < 24) return acq_pkg::BACKSLASH;
		if (r < 44) return pool[$urandom_range(pool.len() - 1)];
		if (r < 50) return 8'h00;
		return 8'($urandom_range(255));
	endfunction

	// Sends one random component; a stretched one overruns the store.
	task automatic send_component(input bit stretch);
		int unsigned cap;
		int unsigned len;
		int unsigned r;
		bit plain;
		bit lone;
		logic [7:0] b;
		cap   = tracker.room();
		r     = $urandom_range(99);
		plain = ($urandom_range(99) < 30);
		lone  = ($urandom_range(2) == 0);
		if ($urandom_range(99) < 4) begin
			// Empty component: a last request that carries no byte.
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
			return;
		end
		if (stretch) len = cap + 3;
		else if (r < 12) len = 1;
		else if (r < 82) len = $urandom_range(2, 10);
		else if (r < 92) len = $urandom_range(2, cap + 1);
		else len = cap + $urandom_range(1, 4);
		for (int i = 0; i < len; i++) begin
			b = (len == 1 && lone) ? acq_pkg::QUOTE : pick_byte(plain);
			send_item(b, $urandom_range(99) >= 8, i == len - 1);
		end
	endtask

	initial begin
		int unsigned phase;
		int unsigned start;
		logic [acq_pkg::LIMIT_W-1:0] lim;
		logic mode;

		tracker      = new();
		arst_n       = 1'b0;
		push         = 1'b0;
		in_byte      = 8'h00;
		byte_present = 1'b0;
		in_last      = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = acq_pkg::REG_CHAR_SET_MODE;
		cfg_data     = '0;
		steady       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Display-name mode at full size: lone quote, empty component, zero byte,
		// quote handling at both ends and inside, a request without a byte.
		write_reg(acq_pkg::REG_CHAR_SET_MODE, acq_pkg::MODE_DISPLAY);
		write_reg(acq_pkg::REG_SIZE_LIMIT, 7'd65);
		send_item(acq_pkg::QUOTE, 1'b1, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(acq_pkg::QUOTE, 1'b1, 1'b0);
		send_item("a", 1'b1, 1'b0);
		send_item(acq_pkg::QUOTE, 1'b1, 1'b0);
		send_item(acq_pkg::BACKSLASH, 1'b1, 1'b0);
		send_item(acq_pkg::QUOTE, 1'b1, 1'b0);
		send_item("b", 1'b1, 1'b0);
		send_item(acq_pkg::QUOTE, 1'b1, 1'b1);
		send_item(".", 1'b1, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item("x", 1'b1, 1'b1);
		send_item("a", 1'b1, 1'b0);
		send_item(" ", 1'b1, 1'b0);
		send_item("b", 1'b1, 1'b1);
		drain();

		// Local-part mode with room for a single byte: overrun and truncated quoting.
		write_reg(acq_pkg::REG_CHAR_SET_MODE, acq_pkg::MODE_LOCAL);
		write_reg(acq_pkg::REG_SIZE_LIMIT, 7'd2);
		send_item("a", 1'b1, 1'b0);
		send_item("b", 1'b1, 1'b0);
		send_item("c", 1'b1, 1'b1);
		send_item("(", 1'b1, 1'b1);
		send_item(" ", 1'b1, 1'b1);
		drain();

		// Random phases, each under its own register setting.
		phase = 0;
		while (tracker.requests < ITEM_TARGET) begin
			case (phase)
				0: lim = 7'd0;
				1: lim = 7'd127;
				2: lim = 7'd1;
				3: lim = 7'd65;
				default: lim = ($urandom_range(9) < 6) ? 7'($urandom_range(3, 64)) :
					7'($urandom_range(66, 126));
			endcase
			if (phase == 0) mode = acq_pkg::MODE_LOCAL;
			else if (phase == 1) mode = acq_pkg::MODE_DISPLAY;
			else mode = 1'($urandom_range(1));
			write_reg(acq_pkg::REG_SIZE_LIMIT, lim);
			write_reg(acq_pkg::REG_CHAR_SET_MODE, mode);
			steady = (phase == 3);
			start  = tracker.requests;
			while (tracker.requests - start < PHASE_ITEMS) begin
				send_component(phase == 1 && tracker.requests == start);
			end
			drain();
			phase++;
		end
		steady = 1'b0;

		$display("Covered %0d requests in %0d components over %0d register writes.",
			tracker.requests, tracker.components, tracker.settings);
		$display("Checked %0d output bytes in both character set modes, limits 0 to 127.",
			tracker.checked);
		if (tracker.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Guard against a hang.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/acq_pkg.sv
rtl/core/acq_fifo.sv
rtl/core/acq_store.sv
rtl/core/acq_front.sv
rtl/core/acq_back.sv
rtl/core/address_component_quoter.sv
tb/tb_top.sv
